/* src/bls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants of the bounded LIFO stack: command and status
// codes, datapath command and status bundles.
// ----------------------------------------------------------------------------
package bls_pkg;

   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_SWAP = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_OVERFLOW  = 2'd1,
      STS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ADDR_FREE = 2'd0,
      ADDR_TOP  = 2'd1,
      ADDR_NEXT = 2'd2
   } addr_sel_type;

   typedef enum logic [1:0] {
      WR_PUSH = 2'd0,
      WR_RAM  = 2'd1,
      WR_TMP  = 2'd2
   } wr_sel_type;

   typedef struct packed {
      logic         rd_en;
      logic         wr_en;
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      logic         tmp_load;
      logic         count_inc;
      logic         count_dec;
      logic         rsp_load;
      logic         rsp_from_ram;
      status_type   rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic two;
      logic full;
      logic rsp_busy;
   } dp_stat_type;

endpackage : bls_pkg
`default_nettype wire

/* src/bounded_lifo_stack_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_lifo_stack_core
// Bounded LIFO stack with push, pop, peek and swap of the top two entries.
//
//   Channel | Dir | Handshake     | Beat contents
//   req     | in  | valid / stall | cmd, push_value
//   rsp     | out | valid / stall | read_value, status, count, is_empty, is_full
//   csr     | in  | valid / ready | capacity (csr_ready always high)
//
// Push and every rejected command are answered in the accepting state. Pop
// and peek: one registered RAM read. Swap: two reads and two writes through
// the single RAM port pair. One command is in flight at a time.
// Reset clears the count and sets capacity to 16; the RAM is not cleared.
// A stalled result holds the next command off until the beat is taken.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_core
   import bls_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [CMD_W-1:0]          req_cmd,
   input  wire logic signed [VALUE_W-1:0] req_push_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_read_value,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_is_empty,
   output logic                           rsp_is_full,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [COUNT_W-1:0]        csr_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   bls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bls_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .push_value     (req_push_value),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

endmodule : bounded_lifo_stack_core
`default_nettype wire

/* src/bls_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bls_ram
`default_nettype wire

/* src/bls_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bls_dpath
// Stack datapath: entry RAM, entry count, capacity register, swap holding
// register and the result register.
// ----------------------------------------------------------------------------
module bls_dpath
   import bls_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   output dp_stat_type                    stat,
   input  wire logic signed [VALUE_W-1:0] push_value,
   input  wire logic                      csr_valid,
   input  wire logic [COUNT_W-1:0]        csr_data,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output logic signed [VALUE_W-1:0]      rsp_read_value,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_is_empty,
   output logic                           rsp_is_full
);

   localparam int AW         = $clog2(DEPTH);
   localparam int XW         = (AW > COUNT_W) ? AW : COUNT_W;
   localparam int DEPTH_CLIP = (DEPTH > 31) ? 31 : DEPTH;
   localparam logic [COUNT_W-1:0] DEPTH_LIM = COUNT_W'(DEPTH_CLIP);

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        cap_ff, cap_in;
   logic [COUNT_W-1:0]        eff_cap;
   logic [DATA_WIDTH-1:0]     tmp_ff, tmp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_empty_ff, rsp_full_ff;

   logic [COUNT_W-1:0]        addr5;
   logic [XW-1:0]             addr_x;
   logic [AW-1:0]             ram_addr;
   logic [DATA_WIDTH-1:0]     ram_wdata, ram_rdata, push_data;
   logic signed [VALUE_W-1:0] ram_wide;

   generate
      if (DATA_WIDTH > VALUE_W) begin : g_wide
         assign push_data = {{(DATA_WIDTH-VALUE_W){1'b0}}, push_value};
         assign ram_wide  = ram_rdata[VALUE_W-1:0];
      end else if (DATA_WIDTH == VALUE_W) begin : g_equal
         assign push_data = push_value;
         assign ram_wide  = ram_rdata;
      end else begin : g_narrow
         assign push_data = push_value[DATA_WIDTH-1:0];
         assign ram_wide  = {{(VALUE_W-DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
      end
   endgenerate

   always_comb begin
      eff_cap = (cap_ff > DEPTH_LIM) ? DEPTH_LIM : cap_ff;

      unique case (cmd.addr_sel)
         ADDR_FREE: addr5 = count_ff;
         ADDR_TOP:  addr5 = count_ff - COUNT_W'(1);
         ADDR_NEXT: addr5 = count_ff - COUNT_W'(2);
         default:   addr5 = count_ff;
      endcase
      addr_x   = XW'(addr5);
      ram_addr = addr_x[AW-1:0];

      unique case (cmd.wr_sel)
         WR_PUSH: ram_wdata = push_data;
         WR_RAM:  ram_wdata = ram_rdata;
         WR_TMP:  ram_wdata = tmp_ff;
         default: ram_wdata = push_data;
      endcase

      priority if (cmd.count_inc) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      cap_in       = csr_valid ? csr_data : cap_ff;
      tmp_in       = cmd.tmp_load ? ram_rdata : tmp_ff;
      rsp_value_in = cmd.rsp_from_ram ? ram_wide : '0;
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);
   end

   bls_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff <= tmp_in;
      if (cmd.rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in >= eff_cap);
      end
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.two      = (count_ff >= COUNT_W'(2));
   assign stat.full     = (count_ff >= eff_cap);
   assign stat.rsp_busy = rsp_valid_ff & rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_LIM)
      else $error("entry count beyond store depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !stat.full)
      else $error("push into full stack");

   a_pop_held: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> !stat.empty)
      else $error("pop from empty stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !stat.rsp_busy)
      else $error("pending result overwritten");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (count_in != count_ff) |-> cmd.rsp_load)
      else $error("count moved without a result");

endmodule : bls_dpath
`default_nettype wire

/* src/bls_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bls_ctrl
// Stack controller: accepts a command, checks it against the count status
// and sequences the RAM reads and writes of the datapath.
// ----------------------------------------------------------------------------
module bls_ctrl
   import bls_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire dp_stat_type       stat,
   output dp_cmd_type             cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_SWAP_A = 5'b00100,
      S_SWAP_B = 5'b01000,
      S_SWAP_C = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      pop_ff, pop_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE) | stat.rsp_busy;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      pop_in   = pop_ff;

      cmd              = '0;
      cmd.addr_sel     = ADDR_TOP;
      cmd.wr_sel       = WR_PUSH;
      cmd.rsp_status   = STS_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_PUSH: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = STS_OVERFLOW;
                     end else begin
                        cmd.wr_en     = 1'b1;
                        cmd.addr_sel  = ADDR_FREE;
                        cmd.count_inc = 1'b1;
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STS_UNDERFLOW;
                     end else begin
                        cmd.rd_en = 1'b1;
                        pop_in    = (cmd_type'(req_cmd) == CMD_POP);
                        state_in  = S_READ;
                     end
                  end
                  CMD_SWAP: begin
                     if (!stat.two) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STS_UNDERFLOW;
                     end else begin
                        cmd.rd_en = 1'b1;
                        state_in  = S_SWAP_A;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_ram = 1'b1;
            cmd.count_dec    = pop_ff;
            state_in         = S_IDLE;
         end
         S_SWAP_A: begin
            cmd.tmp_load = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_NEXT;
            state_in     = S_SWAP_B;
         end
         S_SWAP_B: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_RAM;
            state_in   = S_SWAP_C;
         end
         S_SWAP_C: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = ADDR_NEXT;
            cmd.wr_sel   = WR_TMP;
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pop_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pop_ff   <= pop_in;
      end
   end

endmodule : bls_ctrl
`default_nettype wire
